### rtl/uopf_pkg.sv
// Package for the UTF-8 overlong packet filter.
// Holds the lead code type, the per-packet state struct and the byte constants.
// No dependencies; used by uopf_byte_check and utf8_overlong_packet_filter.
`default_nettype none

package uopf_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAFE_VERDICT = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [7:0] HEADER_BYTES_RESET = 8'd1;
    localparam logic       SAFE_VERDICT_RESET = 1'b0;

    // Verdict codes.
    localparam logic VERDICT_DROP    = 1'b0;
    localparam logic VERDICT_FORWARD = 1'b1;

    // Byte patterns for the overlong tests.
    localparam logic [7:0] LEAD_C0_PAT  = 8'hC0;
    localparam logic [7:0] LEAD_C0_MASK = 8'hFE;
    localparam logic [7:0] LEAD_E0_BYTE = 8'hE0;
    localparam logic [7:0] LEAD_F0_BYTE = 8'hF0;
    localparam logic [7:0] HIGH_F8_MASK = 8'hF8;
    localparam logic [7:0] SECOND_E0_MASK = 8'hE0;
    localparam logic [7:0] SECOND_F0_MASK = 8'hF0;
    localparam logic [7:0] SECOND_TOP     = 8'h80;

    // Lead byte awaiting its second byte.
    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_E0   = 2'd1,
        LEAD_F0   = 2'd2
    } lead_t;

    // Per-packet scanning state.
    typedef struct packed {
        logic [7:0] header_count;
        lead_t      pending_lead;
        logic       decided;
        logic       decided_verdict;
    } pkt_state_t;

    localparam pkt_state_t PKT_STATE_CLEAR = '{
        header_count:    8'd0,
        pending_lead:    LEAD_NONE,
        decided:         1'b0,
        decided_verdict: VERDICT_DROP
    };

endpackage

`default_nettype wire

### rtl/uopf_byte_check.sv
// Combinational per-byte check of the UTF-8 overlong packet filter.
// Takes the current packet state and one byte, gives the next state and verdict.
// Depends on uopf_pkg.
`default_nettype none

module uopf_byte_check
(
    input  wire uopf_pkg::pkt_state_t state_cur,
    input  wire logic [7:0]           byte_value,
    input  wire logic                 last_byte,
    input  wire logic [7:0]           header_bytes,
    input  wire logic                 safe_verdict,
    output uopf_pkg::pkt_state_t      state_next,
    output logic                      verdict
);

    uopf_pkg::pkt_state_t scan;
    logic [7:0] second_mask;
    logic       lead_pending;
    logic       do_parse;
    logic       parse_last;

    // Scan the byte against the header count, a pending lead, or as an ordinary byte.
    always_comb
    begin
        scan         = state_cur;
        second_mask  = uopf_pkg::SECOND_E0_MASK;
        lead_pending = 1'b0;
        do_parse     = 1'b0;
        parse_last   = last_byte;

        case (state_cur.pending_lead)
            uopf_pkg::LEAD_E0:
            begin
                lead_pending = 1'b1;
                second_mask  = uopf_pkg::SECOND_E0_MASK;
            end
            uopf_pkg::LEAD_F0:
            begin
                lead_pending = 1'b1;
                second_mask  = uopf_pkg::SECOND_F0_MASK;
            end
            default:
            begin
                lead_pending = 1'b0;
            end
        endcase

        if (!state_cur.decided)
        begin
            if (state_cur.header_count < header_bytes)
            begin
                scan.header_count = state_cur.header_count + 8'd1;
                if (last_byte)
                begin
                    scan.decided         = 1'b1;
                    scan.decided_verdict = safe_verdict;
                end
            end
            else if (lead_pending)
            begin
                scan.pending_lead = uopf_pkg::LEAD_NONE;
                if ((byte_value & second_mask) == uopf_pkg::SECOND_TOP)
                begin
                    scan.decided         = 1'b1;
                    scan.decided_verdict = uopf_pkg::VERDICT_DROP;
                end
                else if (last_byte)
                begin
                    scan.decided         = 1'b1;
                    scan.decided_verdict = uopf_pkg::VERDICT_FORWARD;
                end
                else
                begin
                    do_parse   = 1'b1;
                    parse_last = 1'b0;
                end
            end
            else
            begin
                scan.pending_lead = uopf_pkg::LEAD_NONE;
                do_parse          = 1'b1;
            end
        end

        // Ordinary parse of a checked byte.
        if (do_parse)
        begin
            if ((byte_value & uopf_pkg::LEAD_C0_MASK) == uopf_pkg::LEAD_C0_PAT)
            begin
                scan.decided         = 1'b1;
                scan.decided_verdict = uopf_pkg::VERDICT_DROP;
            end
            else if ((byte_value == uopf_pkg::LEAD_E0_BYTE)
                     || (byte_value == uopf_pkg::LEAD_F0_BYTE))
            begin
                if (parse_last)
                begin
                    scan.decided         = 1'b1;
                    scan.decided_verdict = safe_verdict;
                end
                else if (byte_value == uopf_pkg::LEAD_E0_BYTE)
                begin
                    scan.pending_lead = uopf_pkg::LEAD_E0;
                end
                else
                begin
                    scan.pending_lead = uopf_pkg::LEAD_F0;
                end
            end
            else if ((byte_value & uopf_pkg::HIGH_F8_MASK) == uopf_pkg::HIGH_F8_MASK)
            begin
                if (parse_last)
                begin
                    scan.decided         = 1'b1;
                    scan.decided_verdict = safe_verdict;
                end
            end
            else if (parse_last)
            begin
                scan.decided         = 1'b1;
                scan.decided_verdict = uopf_pkg::VERDICT_FORWARD;
            end
        end
    end

    // Report the verdict and clear the packet state after the last byte.
    always_comb
    begin
        verdict    = scan.decided ? scan.decided_verdict : safe_verdict;
        state_next = last_byte ? uopf_pkg::PKT_STATE_CLEAR : scan;
    end

endmodule

`default_nettype wire

### rtl/utf8_overlong_packet_filter.sv
// Top level of the UTF-8 overlong packet filter.
// Holds the configuration registers, the packet state and a two-entry result buffer.
// Depends on uopf_pkg and uopf_byte_check.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    byte_value, last_byte
//   out      output     out_valid/out_stall  verdict
//   cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; its check is a single pass of logic
// into the state registers. A verdict is registered when the packet's last byte is taken.
// The output register plus one skid entry keep bytes flowing while a verdict waits;
// in_stall rises only when both entries are full.
// rst_n clears configuration to its reset values, the packet state and both buffer entries.
`default_nettype none

module utf8_overlong_packet_filter
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       byte_value,
    input  wire logic                             last_byte,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  verdict,
    input  wire logic                             cfg_wr_en,
    input  wire logic [uopf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data
);

    logic [7:0]           header_bytes_reg;
    logic                 safe_verdict_reg;
    uopf_pkg::pkt_state_t pkt_reg;
    uopf_pkg::pkt_state_t pkt_next;
    logic                 res_verdict;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_verdict_reg;
    logic                 out_verdict_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic                 skid_verdict_reg;
    logic                 skid_verdict_next;
    logic                 in_accept;
    logic                 res_valid;
    logic                 out_take;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg <= uopf_pkg::HEADER_BYTES_RESET;
            safe_verdict_reg <= uopf_pkg::SAFE_VERDICT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                uopf_pkg::CFG_HEADER_BYTES: header_bytes_reg <= cfg_data;
                uopf_pkg::CFG_SAFE_VERDICT: safe_verdict_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // Handshake decode.
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign res_valid = in_accept && last_byte;
    assign out_take  = out_valid_reg && !out_stall;

    // Per-byte check.
    uopf_byte_check u_byte_check
    (
        .state_cur    (pkt_reg),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .header_bytes (header_bytes_reg),
        .safe_verdict (safe_verdict_reg),
        .state_next   (pkt_next),
        .verdict      (res_verdict)
    );

    // Packet state advances on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg <= uopf_pkg::PKT_STATE_CLEAR;
        end
        else if (in_accept)
        begin
            pkt_reg <= pkt_next;
        end
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_verdict_next  = out_verdict_reg;
        skid_valid_next   = skid_valid_reg;
        skid_verdict_next = skid_verdict_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_verdict_next = skid_verdict_reg;
                skid_valid_next  = 1'b0;
            end
            else
            begin
                out_valid_next   = res_valid;
                out_verdict_next = res_verdict;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next   = 1'b1;
            skid_verdict_next = res_verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_verdict_reg  <= out_verdict_next;
        skid_verdict_reg <= skid_verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = out_verdict_reg;

    // The skid entry is only ever filled behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // A packet's last byte leaves the packet state cleared.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_byte) |=> (pkt_reg == uopf_pkg::PKT_STATE_CLEAR))
        else $error("packet state not cleared after last byte");

    // Once decided, no lead remains pending.
    a_decided_no_lead: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_reg.decided |-> (pkt_reg.pending_lead == uopf_pkg::LEAD_NONE))
        else $error("lead pending on a decided packet");

endmodule

`default_nettype wire
